// File: hdl/vpl_pkg.sv
// shared types and constants of the via point path length block
`default_nettype none

package vpl_pkg;

    localparam int LEN_W      = 32;
    localparam int TS_W       = 32;
    localparam int RATE_STEPS = 2 * LEN_W;
    localparam logic [TS_W-1:0] TS_RESET = 32'd429497;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

// File: hdl/vpl_front.sv
// front end: segment vectors, magnitudes and signs of one item
`default_nettype none

module vpl_front #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic [COORD_WIDTH-1:0]         i_origin_x,
    input  wire logic [COORD_WIDTH-1:0]         i_origin_y,
    input  wire logic [COORD_WIDTH-1:0]         i_origin_z,
    input  wire logic [COORD_WIDTH-1:0]         i_insertion_x,
    input  wire logic [COORD_WIDTH-1:0]         i_insertion_y,
    input  wire logic [COORD_WIDTH-1:0]         i_insertion_z,
    input  wire logic [COORD_WIDTH-1:0]         i_via_x,
    input  wire logic [COORD_WIDTH-1:0]         i_via_y,
    input  wire logic [COORD_WIDTH-1:0]         i_via_z,
    output logic [6*(COORD_WIDTH+1)+5:0]        o_item
);
    localparam int NW = COORD_WIDTH + 1;

    logic signed [NW-1:0] w_a [6];
    logic signed [NW-1:0] w_b [6];
    logic signed [NW-1:0] w_d [6];

    always_comb begin
        w_a[0] = NW'(signed'(i_via_x));
        w_a[1] = NW'(signed'(i_via_y));
        w_a[2] = NW'(signed'(i_via_z));
        w_a[3] = NW'(signed'(i_via_x));
        w_a[4] = NW'(signed'(i_via_y));
        w_a[5] = NW'(signed'(i_via_z));
        w_b[0] = NW'(signed'(i_origin_x));
        w_b[1] = NW'(signed'(i_origin_y));
        w_b[2] = NW'(signed'(i_origin_z));
        w_b[3] = NW'(signed'(i_insertion_x));
        w_b[4] = NW'(signed'(i_insertion_y));
        w_b[5] = NW'(signed'(i_insertion_z));
        o_item = '0;
        for (int k = 0; k < 6; k++) begin
            w_d[k] = w_a[k] - w_b[k];
            o_item[k*NW +: NW] = w_d[k][NW-1] ? NW'(-w_d[k]) : NW'(w_d[k]);
            o_item[6*NW + k]   = w_d[k][NW-1];
        end
    end

endmodule

`default_nettype wire

// File: hdl/vpl_queue.sv
// two entry queue between front and back
`default_nettype none

module vpl_queue #(
    parameter int WIDTH = 204
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output vpl_pkg::t_q_stat      o_stat
);
    import vpl_pkg::*;

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_data       = r_mem[r_rp];
    assign o_stat.full  = r_cnt == 2'd2;
    assign o_stat.empty = r_cnt == 2'd0;

endmodule

`default_nettype wire

// File: hdl/vpl_back.sv
// back end: squares, square roots, divisions and output register
`default_nettype none

module vpl_back #(
    parameter int COORD_WIDTH   = 32,
    parameter int DIR_FRAC_BITS = 14
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [vpl_pkg::TS_W-1:0]          i_cfg_data,
    input  wire logic [6*(COORD_WIDTH+1)+5:0]      i_item,
    input  wire vpl_pkg::t_q_stat                  i_q_stat,
    output logic                                   o_pop,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [vpl_pkg::LEN_W-1:0]              o_path_length,
    output logic [vpl_pkg::LEN_W-1:0]              o_length_rate,
    output logic [DIR_FRAC_BITS+1:0]               o_dir [9],
    output logic                                   o_degenerate
);
    import vpl_pkg::*;

    localparam int NW    = COORD_WIDTH + 1;
    localparam int SW    = 2 * NW;
    localparam int DW    = DIR_FRAC_BITS + 2;
    localparam int QW    = DIR_FRAC_BITS + 1;
    localparam int TW    = NW + 1;
    localparam int CNT_W = $clog2(RATE_STEPS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_SQRT = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_RATE = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]          r_state;
    logic                r_seg;
    logic [1:0]          r_comp;
    logic [CNT_W-1:0]    r_cnt;
    logic [TS_W-1:0]     r_ts;
    logic [LEN_W-1:0]    r_prev;
    logic [NW-1:0]       r_mag [6];
    logic [5:0]          r_neg;
    logic [SW-1:0]       r_acc;
    logic [SW-1:0]       r_ma;
    logic [NW-1:0]       r_mb;
    logic [SW-1:0]       r_rad;
    logic [NW+1:0]       r_rem;
    logic [NW-1:0]       r_root;
    logic [NW-1:0]       r_len1;
    logic [NW-1:0]       r_len2;
    logic [NW:0]         r_dr;
    logic [QW-1:0]       r_dq;
    logic [DW-1:0]       r_u [6];
    logic [LEN_W-1:0]    r_total;
    logic                r_rneg;
    logic [2*LEN_W-1:0]  r_rn;
    logic [LEN_W-1:0]    r_rr;
    logic [LEN_W-2:0]    r_rq;
    logic                r_ovf;
    logic [LEN_W-1:0]    r_rate;

    logic [2:0]          w_idx;
    logic [2:0]          w_nx;
    logic [SW-1:0]       w_acc_n;
    logic [NW+3:0]       w_rem_sh;
    logic [NW+3:0]       w_trial;
    logic                w_sq_ge;
    logic [NW-1:0]       w_root_n;
    logic [NW-1:0]       w_len;
    logic [NW:0]         w_dt;
    logic                w_d_ge;
    logic [QW-1:0]       w_dq_n;
    logic [QW-1:0]       w_qv;
    logic [DW-1:0]       w_u;
    logic [TW+LEN_W-1:0] w_tot_x;
    logic [LEN_W-1:0]    w_total;
    logic                w_tneg;
    logic [LEN_W:0]      w_rt;
    logic                w_r_ge;
    logic [LEN_W-2:0]    w_rq_n;
    logic                w_ovf_n;
    logic [LEN_W-1:0]    w_rate;
    logic                w_slot;

    always_comb begin
        w_idx    = (r_seg ? 3'd3 : 3'd0) + {1'b0, r_comp};
        w_nx     = (r_comp == 2'd2) ? 3'd3 : w_idx + 3'd1;
        w_acc_n  = r_mb[0] ? r_acc + r_ma : r_acc;
        w_rem_sh = {r_rem, r_rad[SW-1 -: 2]};
        w_trial  = {2'b00, r_root, 2'b01};
        w_sq_ge  = w_rem_sh >= w_trial;
        w_root_n = {r_root[NW-2:0], w_sq_ge};
        w_len    = r_seg ? r_len2 : r_len1;
        w_dt     = (r_cnt == '0) ? r_dr : {r_dr[NW-1:0], 1'b0};
        w_d_ge   = w_dt >= {1'b0, w_len};
        w_dq_n   = {r_dq[QW-2:0], w_d_ge};
        if (w_len == '0) begin
            w_qv = '0;
        end else if (r_mag[w_idx] > w_len) begin
            w_qv = QW'(1) << DIR_FRAC_BITS;
        end else begin
            w_qv = w_dq_n;
        end
        w_u      = r_neg[w_idx] ? DW'(-{1'b0, w_qv}) : DW'({1'b0, w_qv});
        w_tot_x  = {{LEN_W{1'b0}}, TW'(r_len1) + TW'(r_len2)};
        w_total  = (|w_tot_x[TW+LEN_W-1:LEN_W]) ? '1 : w_tot_x[LEN_W-1:0];
        w_tneg   = r_total < r_prev;
        w_rt     = {r_rr, r_rn[2*LEN_W-1]};
        w_r_ge   = w_rt >= {1'b0, r_ts};
        w_rq_n   = {r_rq[LEN_W-3:0], w_r_ge};
        w_ovf_n  = r_ovf | (w_r_ge && (r_cnt <= CNT_W'(LEN_W + 1)));
        if (r_rneg) begin
            w_rate = w_ovf_n ? {1'b1, {(LEN_W-1){1'b0}}} : LEN_W'(-{1'b0, w_rq_n});
        end else begin
            w_rate = w_ovf_n ? {1'b0, {(LEN_W-1){1'b1}}} : {1'b0, w_rq_n};
        end
        w_slot   = !o_out_valid || i_out_ready;
    end

    assign o_pop = (r_state == S_IDLE) && !i_q_stat.empty;

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                for (int k = 0; k < 6; k++) begin
                    r_mag[k] <= i_item[k*NW +: NW];
                end
                r_neg  <= i_item[6*NW +: 6];
                r_acc  <= '0;
                r_ma   <= SW'(i_item[0 +: NW]);
                r_mb   <= i_item[0 +: NW];
            end
            S_SQ: begin
                r_acc <= w_acc_n;
                if (r_cnt == CNT_W'(NW-1)) begin
                    r_ma   <= SW'(r_mag[w_nx]);
                    r_mb   <= r_mag[w_nx];
                    r_rad  <= w_acc_n;
                    r_rem  <= '0;
                    r_root <= '0;
                end else begin
                    r_ma  <= r_ma << 1;
                    r_mb  <= r_mb >> 1;
                end
            end
            S_SQRT: begin
                r_rad  <= r_rad << 2;
                r_rem  <= (NW+2)'(w_sq_ge ? w_rem_sh - w_trial : w_rem_sh);
                r_root <= w_root_n;
                if (r_cnt == CNT_W'(NW-1)) begin
                    if (r_seg) begin
                        r_len2 <= w_root_n;
                    end else begin
                        r_len1 <= w_root_n;
                    end
                    r_dr <= {1'b0, r_mag[w_idx]};
                    r_dq <= '0;
                end
            end
            S_DIV: begin
                if (r_cnt == CNT_W'(QW-1)) begin
                    r_u[w_idx] <= w_u;
                    r_dr       <= {1'b0, r_mag[w_nx]};
                    r_dq       <= '0;
                    if (r_comp == 2'd2) begin
                        r_acc   <= '0;
                        r_ma    <= SW'(r_mag[3]);
                        r_mb    <= r_mag[3];
                        r_total <= w_total;
                    end
                end else begin
                    r_dr <= w_d_ge ? w_dt - {1'b0, w_len} : w_dt;
                    r_dq <= w_dq_n;
                end
            end
            S_RATE: begin
                if (r_cnt == '0) begin
                    r_rneg <= w_tneg;
                    r_rn   <= {w_tneg ? r_prev - r_total : r_total - r_prev, {LEN_W{1'b0}}};
                    r_rr   <= '0;
                    r_rq   <= '0;
                    r_rate <= '0;
                end else begin
                    r_rr   <= w_r_ge ? LEN_W'(w_rt - {1'b0, r_ts}) : w_rt[LEN_W-1:0];
                    r_rn   <= r_rn << 1;
                    r_rq   <= w_rq_n;
                    r_rate <= w_rate;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seg       <= 1'b0;
            r_comp      <= 2'd0;
            r_cnt       <= '0;
            r_ts        <= TS_RESET;
            r_prev      <= '0;
            r_ovf       <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ts <= i_cfg_data;
            end
            if (r_state == S_DONE && w_slot) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_stat.empty) begin
                        r_state <= S_SQ;
                        r_seg   <= 1'b0;
                        r_comp  <= 2'd0;
                        r_cnt   <= '0;
                    end
                end
                S_SQ: begin
                    if (r_cnt == CNT_W'(NW-1)) begin
                        r_cnt <= '0;
                        if (r_comp == 2'd2) begin
                            r_comp  <= 2'd0;
                            r_state <= S_SQRT;
                        end else begin
                            r_comp <= r_comp + 2'd1;
                        end
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_SQRT: begin
                    if (r_cnt == CNT_W'(NW-1)) begin
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_DIV: begin
                    if (r_cnt == CNT_W'(QW-1)) begin
                        r_cnt <= '0;
                        if (r_comp == 2'd2) begin
                            r_comp <= 2'd0;
                            if (r_seg) begin
                                r_state <= S_RATE;
                                r_ovf   <= 1'b0;
                            end else begin
                                r_seg   <= 1'b1;
                                r_state <= S_SQ;
                            end
                        end else begin
                            r_comp <= r_comp + 2'd1;
                        end
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_RATE: begin
                    if (r_cnt == '0) begin
                        if (r_ts == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_cnt <= CNT_W'(1);
                        end
                    end else begin
                        r_ovf <= w_ovf_n;
                        if (r_cnt == CNT_W'(RATE_STEPS)) begin
                            r_cnt   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_cnt <= r_cnt + CNT_W'(1);
                        end
                    end
                end
                S_DONE: begin
                    if (w_slot) begin
                        r_prev  <= r_total;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    logic signed [DW:0] w_vmax;
    logic signed [DW:0] w_v [3];

    always_comb begin
        w_vmax = (DW+1)'((1 << (DIR_FRAC_BITS + 1)) - 1);
        for (int k = 0; k < 3; k++) begin
            w_v[k] = -((DW+1)'(signed'(r_u[k])) + (DW+1)'(signed'(r_u[k+3])));
            if (w_v[k] > w_vmax) begin
                w_v[k] = w_vmax;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_slot) begin
            o_path_length <= r_total;
            o_length_rate <= r_rate;
            for (int k = 0; k < 6; k++) begin
                o_dir[k] <= r_u[k];
            end
            for (int k = 0; k < 3; k++) begin
                o_dir[6+k] <= w_v[k][DW-1:0];
            end
            o_degenerate <= (r_len1 == '0) || (r_len2 == '0);
        end
    end

endmodule

`default_nettype wire

// File: hdl/via_point_path_length_and_directions.sv
// top level: path length, length rate and unit directions of a via point path
// each item passes the one bit per cycle units in turn: squares, square roots and divisions
// of each segment, then the length rate division, which is skipped with a zero time step
// the back end starts an item only when done with the last; two items can wait in the queue
// synchronous active low reset clears control, queue and stored length, time step to default
`default_nettype none

module via_point_path_length_and_directions #(
    parameter int COORD_WIDTH   = 32,
    parameter int DIR_FRAC_BITS = 14
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [vpl_pkg::TS_W-1:0]      i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [COORD_WIDTH-1:0]        i_origin_x,
    input  wire logic [COORD_WIDTH-1:0]        i_origin_y,
    input  wire logic [COORD_WIDTH-1:0]        i_origin_z,
    input  wire logic [COORD_WIDTH-1:0]        i_insertion_x,
    input  wire logic [COORD_WIDTH-1:0]        i_insertion_y,
    input  wire logic [COORD_WIDTH-1:0]        i_insertion_z,
    input  wire logic [COORD_WIDTH-1:0]        i_via_x,
    input  wire logic [COORD_WIDTH-1:0]        i_via_y,
    input  wire logic [COORD_WIDTH-1:0]        i_via_z,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [vpl_pkg::LEN_W-1:0]          o_path_length,
    output logic [vpl_pkg::LEN_W-1:0]          o_length_rate,
    output logic [DIR_FRAC_BITS+1:0]           o_origin_dir_x,
    output logic [DIR_FRAC_BITS+1:0]           o_origin_dir_y,
    output logic [DIR_FRAC_BITS+1:0]           o_origin_dir_z,
    output logic [DIR_FRAC_BITS+1:0]           o_insertion_dir_x,
    output logic [DIR_FRAC_BITS+1:0]           o_insertion_dir_y,
    output logic [DIR_FRAC_BITS+1:0]           o_insertion_dir_z,
    output logic [DIR_FRAC_BITS+1:0]           o_via_dir_x,
    output logic [DIR_FRAC_BITS+1:0]           o_via_dir_y,
    output logic [DIR_FRAC_BITS+1:0]           o_via_dir_z,
    output logic                               o_degenerate
);
    import vpl_pkg::*;

    localparam int IW = 6 * (COORD_WIDTH + 1) + 6;

    logic [IW-1:0]          w_front;
    logic [IW-1:0]          w_head;
    t_q_stat                w_q_stat;
    logic                   w_pop;
    logic [DIR_FRAC_BITS+1:0] w_dir [9];

    assign o_in_ready = !w_q_stat.full;

    vpl_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .i_origin_x   (i_origin_x),
        .i_origin_y   (i_origin_y),
        .i_origin_z   (i_origin_z),
        .i_insertion_x(i_insertion_x),
        .i_insertion_y(i_insertion_y),
        .i_insertion_z(i_insertion_z),
        .i_via_x      (i_via_x),
        .i_via_y      (i_via_y),
        .i_via_z      (i_via_z),
        .o_item       (w_front)
    );

    vpl_queue #(
        .WIDTH(IW)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (i_in_valid && o_in_ready),
        .i_data (w_front),
        .i_pop  (w_pop),
        .o_data (w_head),
        .o_stat (w_q_stat)
    );

    vpl_back #(
        .COORD_WIDTH  (COORD_WIDTH),
        .DIR_FRAC_BITS(DIR_FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_item       (w_head),
        .i_q_stat     (w_q_stat),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_path_length(o_path_length),
        .o_length_rate(o_length_rate),
        .o_dir        (w_dir),
        .o_degenerate (o_degenerate)
    );

    assign o_origin_dir_x    = w_dir[0];
    assign o_origin_dir_y    = w_dir[1];
    assign o_origin_dir_z    = w_dir[2];
    assign o_insertion_dir_x = w_dir[3];
    assign o_insertion_dir_y = w_dir[4];
    assign o_insertion_dir_z = w_dir[5];
    assign o_via_dir_x       = w_dir[6];
    assign o_via_dir_y       = w_dir[7];
    assign o_via_dir_z       = w_dir[8];

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_degenerate) |-> (o_path_length != '0))
        else $error("zero length without degenerate flag");

    a_queue_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_stat.full |-> !w_q_stat.empty)
        else $error("queue full and empty");

    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// self-checking testbench of the via point path length and directions block
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW  = 32;
    localparam int DFB = 14;
    localparam int DW  = DFB + 2;
    localparam int LATENCY = 2 * (4 * CW + 3 * DFB + 7) + 70;

    typedef struct {
        logic [CW-1:0] pt [9];
    } t_points;

    typedef struct {
        logic [31:0]   len;
        logic [31:0]   rate;
        logic [DW-1:0] dir [9];
        logic          degen;
    } t_path;

    class path_scoreboard;
        t_path       pending [$];
        logic [31:0] step_size;
        logic [31:0] last_len;
        int          mismatches;

        function new();
            step_size  = vpl_pkg::TS_RESET;
            last_len   = '0;
            mismatches = 0;
        endfunction

        function automatic logic [63:0] seg_root(logic [63:0] m [3]);
            logic [127:0] s;
            logic [63:0]  r;
            logic [63:0]  c;
            s = 128'(m[0]) * m[0] + 128'(m[1]) * m[1] + 128'(m[2]) * m[2];
            r = 0;
            for (int b = 50; b >= 0; b--) begin
                c = r | (64'd1 << b);
                if (128'(c) * c <= s) r = c;
            end
            return r;
        endfunction

        function automatic void segment(logic signed [63:0] d [3],
                                        output logic signed [63:0] u [3],
                                        output logic [63:0] len);
            logic [63:0] m [3];
            logic [63:0] q;
            for (int k = 0; k < 3; k++) m[k] = d[k] < 0 ? -d[k] : d[k];
            len = seg_root(m);
            for (int k = 0; k < 3; k++) begin
                q = 0;
                if (len != 0) begin
                    if (m[k] > len) q = 64'd1 << DFB;
                    else q = (m[k] << DFB) / len;
                end
                u[k] = d[k] < 0 ? -$signed(q) : $signed(q);
            end
        endfunction

        function void note_input(t_points p);
            logic signed [63:0] d1 [3];
            logic signed [63:0] d2 [3];
            logic signed [63:0] u1 [3];
            logic signed [63:0] u2 [3];
            logic signed [63:0] v;
            logic [63:0] l1, l2, tot, mag, q;
            t_path e;
            for (int k = 0; k < 3; k++) begin
                d1[k] = 64'($signed(p.pt[6+k])) - 64'($signed(p.pt[k]));
                d2[k] = 64'($signed(p.pt[6+k])) - 64'($signed(p.pt[3+k]));
            end
            segment(d1, u1, l1);
            segment(d2, u2, l2);
            tot = l1 + l2;
            if (tot > 64'hFFFF_FFFF) tot = 64'hFFFF_FFFF;
            e.rate = '0;
            if (step_size != 0) begin
                if (tot < last_len) begin
                    mag = last_len - tot;
                    q = (mag << 32) / step_size;
                    e.rate = q >= 64'h8000_0000 ? 32'h8000_0000 : 32'(-q);
                end else begin
                    mag = tot - last_len;
                    q = (mag << 32) / step_size;
                    e.rate = q > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : 32'(q);
                end
            end
            last_len = tot[31:0];
            e.len = tot[31:0];
            for (int k = 0; k < 3; k++) begin
                v = -(u1[k] + u2[k]);
                if (v > (64'sd1 <<< (DFB + 1)) - 1) v = (64'sd1 <<< (DFB + 1)) - 1;
                e.dir[k]   = u1[k][DW-1:0];
                e.dir[3+k] = u2[k][DW-1:0];
                e.dir[6+k] = v[DW-1:0];
            end
            e.degen = (l1 == 0 || l2 == 0);
            pending.insert(pending.size(), e);
        endfunction

        function void report(string what, logic [31:0] exp_v, logic [31:0] act_v);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h actual %h", what, exp_v, act_v);
        endfunction

        function void check_result(t_path a);
            t_path e;
            if (pending.size() == 0) begin
                report("unexpected item", 0, a.len);
                return;
            end
            e = pending.pop_front();
            if (a.len !== e.len) report("path_length", e.len, a.len);
            if (a.rate !== e.rate) report("length_rate", e.rate, a.rate);
            for (int k = 0; k < 9; k++)
                if (a.dir[k] !== e.dir[k]) report($sformatf("dir[%0d]", k), e.dir[k], a.dir[k]);
            if (a.degen !== e.degen) report("degenerate", e.degen, a.degen);
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [31:0]   i_cfg_data;
    logic          i_in_valid;
    wire           o_in_ready;
    logic [CW-1:0] pts [9];
    wire           o_out_valid;
    logic          i_out_ready;
    wire [31:0]    o_path_length;
    wire [31:0]    o_length_rate;
    wire [DW-1:0]  odir [9];
    wire           o_degenerate;

    path_scoreboard sb;
    bit             stim_done;
    bit             hold_off;

    via_point_path_length_and_directions #(.COORD_WIDTH(CW), .DIR_FRAC_BITS(DFB)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_origin_x(pts[0]), .i_origin_y(pts[1]), .i_origin_z(pts[2]),
        .i_insertion_x(pts[3]), .i_insertion_y(pts[4]), .i_insertion_z(pts[5]),
        .i_via_x(pts[6]), .i_via_y(pts[7]), .i_via_z(pts[8]),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_path_length(o_path_length), .o_length_rate(o_length_rate),
        .o_origin_dir_x(odir[0]), .o_origin_dir_y(odir[1]), .o_origin_dir_z(odir[2]),
        .o_insertion_dir_x(odir[3]), .o_insertion_dir_y(odir[4]),
        .o_insertion_dir_z(odir[5]),
        .o_via_dir_x(odir[6]), .o_via_dir_y(odir[7]), .o_via_dir_z(odir[8]),
        .o_degenerate(o_degenerate)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 600) : $urandom_range(0, 3);
    endfunction

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 20000)) - 10000);
            2: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
            default: return ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
        endcase
    endfunction

    task automatic send_points(t_points p);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        for (int k = 0; k < 9; k++) pts[k] <= p.pt[k];
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(p);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (gap_len()) @(negedge i_clk);
    endtask

    task automatic write_step(logic [31:0] v);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.step_size = v;
    endtask

    task automatic random_points(int n);
        t_points p;
        int mode;
        for (int i = 0; i < n; i++) begin
            mode = $urandom_range(0, 9);
            for (int k = 0; k < 9; k++)
                p.pt[k] = rand_coord(mode < 3 ? 0 : mode < 6 ? 1 : mode < 9 ? 2 : $urandom_range(0, 3));
            if ($urandom_range(0, 11) == 0)
                for (int k = 0; k < 3; k++) p.pt[6+k] = p.pt[$urandom_range(0, 1) * 3 + k];
            send_points(p);
        end
    endtask

    initial begin
        t_points p;
        sb = new();
        i_rst_n = 0; i_cfg_we = 0; i_cfg_data = '0; i_in_valid = 0; i_out_ready = 0;
        for (int k = 0; k < 9; k++) pts[k] = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // all zero: both segments degenerate
        for (int k = 0; k < 9; k++) p.pt[k] = '0;
        send_points(p);
        // extremes: long path saturation
        for (int k = 0; k < 9; k++) p.pt[k] = (k >= 6) ? 32'h7FFF_FFFF : 32'h8000_0000;
        send_points(p);
        for (int k = 0; k < 9; k++) p.pt[k] = (k >= 6) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        send_points(p);
        // opposed axis segments make the via sum overflow
        for (int k = 0; k < 9; k++) p.pt[k] = '0;
        p.pt[0] = 32'hFFFF_0000; p.pt[3] = 32'hFFFE_0000;
        send_points(p);
        p.pt[0] = 32'h0001_0000; p.pt[3] = 32'h0002_0000;
        send_points(p);
        // one degenerate segment
        for (int k = 0; k < 9; k++) p.pt[k] = 32'(k * 32'h0001_2345);
        for (int k = 0; k < 3; k++) p.pt[3+k] = p.pt[6+k];
        send_points(p);
        // tiny lengths
        for (int k = 0; k < 9; k++) p.pt[k] = '0;
        p.pt[6] = 1; p.pt[7] = 32'hFFFF_FFFF;
        send_points(p);
        random_points(15);
        write_step('0);
        random_points(40);
        write_step(32'hFFFF_FFFF);
        random_points(40);
        write_step(32'd1);
        random_points(40);
        // receiver holds off while inputs queue up
        hold_off = 1;
        random_points(8);
        hold_off = 0;
        write_step(32'd65536);
        random_points(200);
        write_step($urandom);
        random_points(200);
        stim_done = 1;
    end

    initial begin
        int hold;
        bit held;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off && !held) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                hold = 3000;
                repeat (hold) @(negedge i_clk);
            end
            if ($urandom_range(0, 40) == 0) begin
                i_out_ready <= 1'b0;
                repeat (gap_len()) @(negedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_path a;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            a.len = o_path_length;
            a.rate = o_length_rate;
            for (int k = 0; k < 9; k++) a.dir[k] = odir[k];
            a.degen = o_degenerate;
            sb.check_result(a);
        end
    end

    initial begin
        wait (stim_done);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #40ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule

`default_nettype wire
